### rtl/dmm_pkg.sv
// Package for the division magic multiplier core: field widths, item layout and state codes.
`timescale 1ns / 1ps

package dmm_pkg;

    localparam int DIV_W      = 31;
    localparam int MULT_W     = 33;
    localparam int SHIFT_W    = 5;
    localparam int PREC_W     = 6;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;
    localparam int M_FIELDS_W = MULT_W + 2 * SHIFT_W;

    localparam logic [PREC_W-1:0]  PREC_RESET = 6'd31;
    localparam logic [PREC_W-1:0]  PREC_MIN   = 6'd1;
    localparam logic [SHIFT_W-1:0] LOG_START  = 5'd31;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_LOG   = 5'b00010,
        S_DIV   = 5'b00100,
        S_HALVE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

endpackage

### rtl/division_magic_multiplier_core.sv
// Top level of the division magic multiplier core: bit-serial divider and shift chooser.
`timescale 1ns / 1ps

// Takes a divisor d on the slave stream and returns the magic multiplier, post-shift and
// ceil(log2 d) for dividing WORD_BITS-bit values by d with a multiply-high and a shift.
// One item is worked on at a time; the next item is taken while the last result waits in
// the output register. An item with ceiling log l and k halving steps (k <= l) goes through
// a leading-one scan of d - 1, the restoring divider that produces both bounds one quotient
// bit per cycle, the halving steps and a load of the output, which waits until the output
// register is free. A zero divisor skips to the load and returns all zeros. The precision
// register is clamped to 1..WORD_BITS when used.
module division_magic_multiplier_core #(
    parameter int WORD_BITS = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [dmm_pkg::PREC_W-1:0]      cfg_wdata,      // precision
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dmm_pkg::S_TDATA_W-1:0]   s_tdata,        // [30:0] divisor
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dmm_pkg::M_TDATA_W-1:0]   m_tdata         // [32:0] multiplier,
                                                            // [37:33] post_shift,
                                                            // [42:38] ceil_log2
);

    localparam int DW = dmm_pkg::DIV_W;
    localparam int SW = dmm_pkg::SHIFT_W;
    localparam int PW = dmm_pkg::PREC_W;
    localparam int QW = WORD_BITS + 2;
    localparam int TW = $clog2(WORD_BITS + 32);

    dmm_pkg::state_t          state_reg, state_next;
    logic [PW-1:0]            prec_reg, prec_next;
    logic [DW-1:0]            d_reg, d_next;
    logic [DW-1:0]            scan_reg, scan_next;
    logic [SW-1:0]            cnt_reg, cnt_next;
    logic [SW-1:0]            l_reg, l_next;
    logic [SW-1:0]            sh_reg, sh_next;
    logic [TW-1:0]            top_reg, top_next;
    logic [TW-1:0]            hp_reg, hp_next;
    logic [TW-1:0]            idx_reg, idx_next;
    logic [DW-1:0]            rem_lo_reg, rem_lo_next;
    logic [DW-1:0]            rem_hi_reg, rem_hi_next;
    logic [QW-1:0]            lo_reg, lo_next;
    logic [QW-1:0]            hi_reg, hi_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [dmm_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [PW-1:0]            prec_eff;
    logic [TW-1:0]            top_calc;
    logic                     bit_lo, bit_hi;
    logic [DW:0]              rem_lo_sh, rem_hi_sh, d_ext;
    logic [DW:0]              diff_lo, diff_hi;
    logic                     ge_lo, ge_hi;
    logic                     can_halve;
    logic [QW+dmm_pkg::MULT_W-1:0] mult_ext;
    logic                     out_free;

    assign s_tready = (state_reg == dmm_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        priority if (prec_reg < dmm_pkg::PREC_MIN)
        begin
            prec_eff = dmm_pkg::PREC_MIN;
        end
        else if (prec_reg > PW'(WORD_BITS))
        begin
            prec_eff = PW'(WORD_BITS);
        end
        else
        begin
            prec_eff = prec_reg;
        end
    end

    // Dividend bits: 2^top for the low bound, 2^top + 2^(top - prec) for the high bound.
    assign top_calc  = TW'(WORD_BITS) + TW'(cnt_reg);
    assign bit_lo    = (idx_reg == top_reg);
    assign bit_hi    = bit_lo || (idx_reg == hp_reg);
    assign d_ext     = {1'b0, d_reg};
    assign rem_lo_sh = {rem_lo_reg, bit_lo};
    assign rem_hi_sh = {rem_hi_reg, bit_hi};
    assign ge_lo     = (rem_lo_sh >= d_ext);
    assign ge_hi     = (rem_hi_sh >= d_ext);
    assign diff_lo   = rem_lo_sh - d_ext;
    assign diff_hi   = rem_hi_sh - d_ext;
    assign can_halve = (lo_reg[QW-1:1] < hi_reg[QW-1:1]) && (sh_reg != '0);
    assign mult_ext  = {{dmm_pkg::MULT_W{1'b0}}, hi_reg};

    always_comb
    begin
        state_next    = state_reg;
        prec_next     = cfg_wen ? cfg_wdata : prec_reg;
        d_next        = d_reg;
        scan_next     = scan_reg;
        cnt_next      = cnt_reg;
        l_next        = l_reg;
        sh_next       = sh_reg;
        top_next      = top_reg;
        hp_next       = hp_reg;
        idx_next      = idx_reg;
        rem_lo_next   = rem_lo_reg;
        rem_hi_next   = rem_hi_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        unique case (state_reg)
            dmm_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    d_next    = s_tdata[DW-1:0];
                    scan_next = s_tdata[DW-1:0] - DW'(1);
                    cnt_next  = dmm_pkg::LOG_START;
                    if (s_tdata[DW-1:0] == '0)
                    begin
                        hi_next    = '0;
                        sh_next    = '0;
                        l_next     = '0;
                        state_next = dmm_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = dmm_pkg::S_LOG;
                    end
                end
            end
            dmm_pkg::S_LOG:
            begin
                // Bit length of d - 1 is ceil(log2 d); scan from the top bit down.
                if (scan_reg[DW-1] || (cnt_reg == '0))
                begin
                    l_next      = cnt_reg;
                    top_next    = top_calc;
                    hp_next     = top_calc - TW'(prec_eff);
                    idx_next    = top_calc;
                    rem_lo_next = '0;
                    rem_hi_next = '0;
                    lo_next     = '0;
                    hi_next     = '0;
                    state_next  = dmm_pkg::S_DIV;
                end
                else
                begin
                    scan_next = {scan_reg[DW-2:0], 1'b0};
                    cnt_next  = cnt_reg - SW'(1);
                end
            end
            dmm_pkg::S_DIV:
            begin
                rem_lo_next = ge_lo ? diff_lo[DW-1:0] : rem_lo_sh[DW-1:0];
                rem_hi_next = ge_hi ? diff_hi[DW-1:0] : rem_hi_sh[DW-1:0];
                lo_next     = {lo_reg[QW-2:0], ge_lo};
                hi_next     = {hi_reg[QW-2:0], ge_hi};
                idx_next    = idx_reg - TW'(1);
                if (idx_reg == '0)
                begin
                    sh_next    = l_reg;
                    state_next = dmm_pkg::S_HALVE;
                end
            end
            dmm_pkg::S_HALVE:
            begin
                if (can_halve)
                begin
                    lo_next = lo_reg >> 1;
                    hi_next = hi_reg >> 1;
                    sh_next = sh_reg - SW'(1);
                end
                else
                begin
                    state_next = dmm_pkg::S_DONE;
                end
            end
            dmm_pkg::S_DONE:
            begin
                // Hold until the output register is free.
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = dmm_pkg::M_TDATA_W'({l_reg, sh_reg,
                                                         mult_ext[dmm_pkg::MULT_W-1:0]});
                    state_next    = dmm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = dmm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dmm_pkg::S_IDLE;
            prec_reg     <= dmm_pkg::PREC_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            prec_reg     <= prec_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg       <= d_next;
        scan_reg    <= scan_next;
        cnt_reg     <= cnt_next;
        l_reg       <= l_next;
        sh_reg      <= sh_next;
        top_reg     <= top_next;
        hp_reg      <= hp_next;
        idx_reg     <= idx_next;
        rem_lo_reg  <= rem_lo_next;
        rem_hi_reg  <= rem_hi_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        m_tdata_reg <= m_tdata_next;
    end

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dmm_pkg::S_DIV) |-> ((rem_lo_reg < d_reg) && (rem_hi_reg < d_reg)))
        else $error("divider remainder not below divisor");

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dmm_pkg::S_HALVE) |-> (lo_reg <= hi_reg))
        else $error("low bound exceeds high bound");

    a_shift_within_log: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dmm_pkg::S_HALVE) |-> (sh_reg <= l_reg))
        else $error("post-shift exceeds ceiling log");

    a_out_shift_le_log: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (m_tdata_reg[dmm_pkg::MULT_W +: dmm_pkg::SHIFT_W]
                          <= m_tdata_reg[dmm_pkg::MULT_W + dmm_pkg::SHIFT_W +: dmm_pkg::SHIFT_W]))
        else $error("result post-shift exceeds ceiling log");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg != dmm_pkg::S_IDLE))
        else $error("accepted item did not start work");
`endif

endmodule
